FILE: rtl/vertex_transform_4x4_macros.svh
// ----------------------------------------------------------------------------
// vertex_transform_4x4 assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH

// same-cycle implication
`define VT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/vt4x4_pkg.sv
// ----------------------------------------------------------------------------
// vt4x4_pkg
// Constants and types for the 4x4 fixed-point vertex transform.
// ----------------------------------------------------------------------------
package vt4x4_pkg;

   localparam int NUM_ROWS        = 4;
   localparam int NUM_COLUMNS     = 4;
   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC_BITS  = 12;
   localparam int CSR_DATA_WIDTH  = NUM_ROWS * COEF_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [CSR_DATA_WIDTH-1:0] column_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COLUMN0 = 3'd0,
      CSR_COLUMN1 = 3'd1,
      CSR_COLUMN2 = 3'd2,
      CSR_COLUMN3 = 3'd3
   } csr_index_type;

   // identity: 1.0 in Q4.12 on the diagonal
   localparam column_type COLUMN_RESET [NUM_COLUMNS] = '{
      64'h0000_0000_0000_1000,
      64'h0000_0000_1000_0000,
      64'h0000_1000_0000_0000,
      64'h1000_0000_0000_0000
   };

endpackage

FILE: rtl/vertex_transform_4x4.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Multiplies a Q16.16 homogeneous vertex by a 4x4 Q4.12 column-major matrix.
// ----------------------------------------------------------------------------
// Accepts one vertex per cycle unless req_stall is high; each vertex taken
// passes through sixteen parallel coefficient-by-component
// multipliers, then a pairwise add, a final add, and a floor shift by 12 with
// saturation to COMPONENT_WIDTH, each in a register stage of its own. Stages
// advance independently, so bubbles close up and a stalled result does not
// block input until all four stages hold a transaction. The matrix resets to
// identity; write columns only while no transaction is in flight.
`include "vertex_transform_4x4_macros.svh"

module vertex_transform_4x4 #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      csr_write_enable,
   input  logic [vt4x4_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [vt4x4_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,

   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [COMPONENT_WIDTH-1:0]         req_vertex_x,
   input  logic signed [COMPONENT_WIDTH-1:0]         req_vertex_y,
   input  logic signed [COMPONENT_WIDTH-1:0]         req_vertex_z,
   input  logic signed [COMPONENT_WIDTH-1:0]         req_vertex_w,

   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [COMPONENT_WIDTH-1:0]         rsp_out_x,
   output logic signed [COMPONENT_WIDTH-1:0]         rsp_out_y,
   output logic signed [COMPONENT_WIDTH-1:0]         rsp_out_z,
   output logic signed [COMPONENT_WIDTH-1:0]         rsp_out_w
);

   import vt4x4_pkg::*;

   localparam int PROD_WIDTH  = COMPONENT_WIDTH + COEF_WIDTH;
   localparam int PAIR_WIDTH  = PROD_WIDTH + 1;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int SHIFT_WIDTH = SUM_WIDTH - COEF_FRAC_BITS;
   localparam int HEAD_WIDTH  = SHIFT_WIDTH - COMPONENT_WIDTH + 1;

   localparam logic signed [COMPONENT_WIDTH-1:0] SAT_MAX =
      {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
   localparam logic signed [COMPONENT_WIDTH-1:0] SAT_MIN =
      {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

   column_type                        column_ff [NUM_COLUMNS];

   logic signed [COMPONENT_WIDTH-1:0] vert [NUM_COLUMNS];

   logic                              s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic                              s1_ready, s2_ready, s3_ready, rsp_ready;

   logic signed [PROD_WIDTH-1:0]      prod_in [NUM_ROWS][NUM_COLUMNS];
   logic signed [PROD_WIDTH-1:0]      prod_ff [NUM_ROWS][NUM_COLUMNS];
   logic signed [PAIR_WIDTH-1:0]      pair_in [NUM_ROWS][2];
   logic signed [PAIR_WIDTH-1:0]      pair_ff [NUM_ROWS][2];
   logic signed [SUM_WIDTH-1:0]       sum_in  [NUM_ROWS];
   logic signed [SUM_WIDTH-1:0]       sum_ff  [NUM_ROWS];
   logic [SHIFT_WIDTH-1:0]            shifted [NUM_ROWS];
   logic [HEAD_WIDTH-1:0]             head    [NUM_ROWS];
   logic signed [COMPONENT_WIDTH-1:0] out_in  [NUM_ROWS];
   logic signed [COMPONENT_WIDTH-1:0] out_ff  [NUM_ROWS];

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            column_ff[c] <= COLUMN_RESET[c];
         end
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMN0: column_ff[0] <= csr_write_data;
            CSR_COLUMN1: column_ff[1] <= csr_write_data;
            CSR_COLUMN2: column_ff[2] <= csr_write_data;
            CSR_COLUMN3: column_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign vert[0] = req_vertex_x;
   assign vert[1] = req_vertex_y;
   assign vert[2] = req_vertex_z;
   assign vert[3] = req_vertex_w;

   // per-stage flow control
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff  || rsp_ready;
   assign s2_ready  = !s2_valid_ff  || s3_ready;
   assign s1_ready  = !s1_valid_ff  || s2_ready;
   assign req_stall = !s1_ready;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            prod_in[r][c] = PROD_WIDTH'($signed(column_ff[c][r*COEF_WIDTH +: COEF_WIDTH]))
                          * PROD_WIDTH'(vert[c]);
         end
         for (int k = 0; k < 2; k++) begin
            pair_in[r][k] = PAIR_WIDTH'(prod_ff[r][2*k]) + PAIR_WIDTH'(prod_ff[r][2*k+1]);
         end
         sum_in[r]  = SUM_WIDTH'(pair_ff[r][0]) + SUM_WIDTH'(pair_ff[r][1]);
         // floor shift is a plain drop of the low bits
         shifted[r] = sum_ff[r][SUM_WIDTH-1:COEF_FRAC_BITS];
         head[r]    = shifted[r][SHIFT_WIDTH-1:COMPONENT_WIDTH-1];
         if ((&head[r]) || !(|head[r])) begin
            out_in[r] = $signed(shifted[r][COMPONENT_WIDTH-1:0]);
         end else if (shifted[r][SHIFT_WIDTH-1]) begin
            out_in[r] = SAT_MIN;
         end else begin
            out_in[r] = SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         prod_ff <= prod_in;
      end
      if (s2_ready && s1_valid_ff) begin
         pair_ff <= pair_in;
      end
      if (s3_ready && s2_valid_ff) begin
         sum_ff <= sum_in;
      end
      if (rsp_ready && s3_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];
   assign rsp_out_w = out_ff[3];

   // input blocks whenever every stage holds a transaction and the output waits
   `VT_ASSERT_NOW(a_full_stalls, rsp_valid_ff && rsp_stall && s1_valid_ff && s2_valid_ff && s3_valid_ff, req_stall, "pipeline full but input not stalled")
   // a transaction entering an empty pipeline passes through every stage and reaches the output
   `VT_ASSERT_NOW(a_latency, req_valid && !req_stall && !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !rsp_valid_ff, ##4 rsp_valid_ff, "transaction lost in empty pipeline")
   // result leaves only when taken
   `VT_ASSERT_NEXT(a_hold, rsp_valid_ff && rsp_stall, rsp_valid_ff, "stalled result dropped")

endmodule
